FILE: hw/rtl/wfem_pkg.sv
`default_nettype none

package wfem_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;
  localparam int unsigned MAX_WINDOW_DEF = 7;

  localparam int unsigned COORD_W  = 8;
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned OFS_W    = 3;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned SIDE_W   = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned RAW_W    = 10;
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned APB_DW   = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_WINDOW = 1'b1;

  localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_WINDOW_SIDE    = 3'd2;
  localparam logic [2:0] REG_EDGE_MODE      = 3'd3;
  localparam logic [2:0] REG_CHANNEL_SELECT = 3'd4;

  localparam logic [MODE_W-1:0] EDGE_WRAP  = 2'd0;
  localparam logic [MODE_W-1:0] EDGE_BLACK = 2'd1;
  localparam logic [MODE_W-1:0] EDGE_CLAMP = 2'd2;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_GRAY  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_RUN
  } fetch_state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic [OFS_W-1:0]    offset_col;
    logic [OFS_W-1:0]    offset_row;
    logic                last_of_window;
  } sample_t;

  typedef struct packed {
    logic             black;
    logic [OFS_W-1:0] col;
    logic [OFS_W-1:0] row;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic              ok;
    logic [SIZE_W-1:0] coord;
  } resolved_t;

  function automatic resolved_t resolve(input logic signed [RAW_W-1:0] raw,
                                        input logic [SIZE_W-1:0] wrapped,
                                        input logic [SIZE_W-1:0] n,
                                        input logic [MODE_W-1:0] mode);
    resolved_t res;
    res.ok    = 1'b1;
    res.coord = raw[SIZE_W-1:0];
    if (raw[RAW_W-1] || (raw[SIZE_W-1:0] >= n)) begin
      case (mode)
        EDGE_WRAP: begin
          res.coord = wrapped;
        end
        EDGE_CLAMP: begin
          res.coord = raw[RAW_W-1] ? '0 : n - SIZE_W'(1);
        end
        default: begin
          res.ok    = 1'b0;
          res.coord = '0;
        end
      endcase
    end
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] channel_of(input logic [RGB_W-1:0] px,
                                                     input logic [1:0] sel);
    logic [12:0] sum;
    sum = 13'(px[23:16]) * 13'd11 + 13'(px[15:8]) * 13'd16 + 13'(px[7:0]) * 13'd5;
    case (sel)
      CH_RED:   return px[23:16];
      CH_GREEN: return px[15:8];
      CH_BLUE:  return px[7:0];
      default:  return sum[12:5];
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wfem_if.sv
`default_nettype none

interface wfem_req_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [wfem_pkg::COORD_W-1:0]        coord_x;
  logic [wfem_pkg::COORD_W-1:0]        coord_y;
  logic [wfem_pkg::RGB_W-1:0]          pixel_rgb;

  modport source(output valid, cmd, coord_x, coord_y, pixel_rgb, input ready);
  modport sink(input valid, cmd, coord_x, coord_y, pixel_rgb, output ready);
endinterface

interface wfem_smp_if;
  logic                                valid;
  logic                                ready;
  logic [wfem_pkg::SAMPLE_W-1:0]       sample_value;
  logic [wfem_pkg::OFS_W-1:0]          offset_col;
  logic [wfem_pkg::OFS_W-1:0]          offset_row;
  logic                                last_of_window;

  modport source(output valid, sample_value, offset_col, offset_row, last_of_window,
                 input ready);
  modport sink(input valid, sample_value, offset_col, offset_row, last_of_window,
               output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/window_fetch_with_edge_modes_core.sv
// Write item: stored at the accept edge.
// Window request: input held not ready while the n*n samples (n = effective window side) are produced:
//   bit-serial modulo of the start column and row, a fix-up step,
//   then one pixel memory read per sample through the single read port.
// Samples then follow one per cycle while the output queue has room.
// Reset: configuration returns to 256, 256, 3, 1, 3; the pixel memory is not cleared.
`default_nettype none

module window_fetch_with_edge_modes_core #(
  parameter int unsigned MAX_WIDTH  = wfem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = wfem_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_WINDOW = wfem_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wfem_pkg::APB_AW-1:0]   paddr,
  input  logic [wfem_pkg::APB_DW-1:0]   pwdata,
  output logic [wfem_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  wfem_req_if.sink                      req_i,
  wfem_smp_if.source                    smp_o
);

  localparam int unsigned XW       = $clog2(MAX_WIDTH);
  localparam int unsigned YW       = $clog2(MAX_HEIGHT);
  localparam int unsigned AW       = XW + YW;
  localparam int unsigned DEPTH    = 2 ** AW;
  localparam int unsigned MAX_HALF = (MAX_WINDOW - 1) / 2;

  localparam int unsigned SW  = wfem_pkg::SIZE_W;
  localparam int unsigned RW  = wfem_pkg::RAW_W;
  localparam int unsigned CW  = wfem_pkg::COORD_W;
  localparam int unsigned OW  = wfem_pkg::OFS_W;

  // configuration
  logic [SW-1:0]                 width_q, height_q;
  logic [wfem_pkg::SIDE_W-1:0]   side_q;
  logic [wfem_pkg::MODE_W-1:0]   mode_q;
  logic [1:0]                    chan_q;
  logic                          cfg_we;
  logic [2:0]                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SW'(256);
      height_q <= SW'(256);
      side_q   <= 3'd3;
      mode_q   <= wfem_pkg::EDGE_BLACK;
      chan_q   <= wfem_pkg::CH_GRAY;
    end else if (cfg_we) begin
      case (cfg_idx)
        wfem_pkg::REG_IMAGE_WIDTH:    width_q  <= pwdata[SW-1:0];
        wfem_pkg::REG_IMAGE_HEIGHT:   height_q <= pwdata[SW-1:0];
        wfem_pkg::REG_WINDOW_SIDE:    side_q   <= pwdata[wfem_pkg::SIDE_W-1:0];
        wfem_pkg::REG_EDGE_MODE:      mode_q   <= pwdata[wfem_pkg::MODE_W-1:0];
        wfem_pkg::REG_CHANNEL_SELECT: chan_q   <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      wfem_pkg::REG_IMAGE_WIDTH:    prdata = wfem_pkg::APB_DW'(width_q);
      wfem_pkg::REG_IMAGE_HEIGHT:   prdata = wfem_pkg::APB_DW'(height_q);
      wfem_pkg::REG_WINDOW_SIDE:    prdata = wfem_pkg::APB_DW'(side_q);
      wfem_pkg::REG_EDGE_MODE:      prdata = wfem_pkg::APB_DW'(mode_q);
      wfem_pkg::REG_CHANNEL_SELECT: prdata = wfem_pkg::APB_DW'(chan_q);
      default:                      prdata = '0;
    endcase
  end

  // effective geometry
  logic [SW-1:0] eff_w, eff_h;
  logic [1:0]    half;
  logic [OW-1:0] last_idx;

  assign eff_w = (width_q == '0) ? SW'(1) :
                 (32'(width_q) > MAX_WIDTH) ? SW'(MAX_WIDTH) : width_q;
  assign eff_h = (height_q == '0) ? SW'(1) :
                 (32'(height_q) > MAX_HEIGHT) ? SW'(MAX_HEIGHT) : height_q;
  assign half     = (side_q[2:1] > 2'(MAX_HALF)) ? 2'(MAX_HALF) : side_q[2:1];
  assign last_idx = {half, 1'b0};

  // control
  wfem_pkg::fetch_state_e state_q, state_d;
  logic          req_fire, start, div_en, fix_en, issue, credit_ok, last_issue;
  logic [2:0]    bit_q;
  logic [OW-1:0] col_q, row_q;

  assign req_fire   = req_i.valid & req_i.ready;
  assign start      = req_fire & (req_i.cmd == wfem_pkg::CMD_WINDOW);
  assign last_issue = (col_q == last_idx) && (row_q == last_idx);

  always_comb begin
    state_d = state_q;
    case (state_q)
      wfem_pkg::ST_IDLE: if (start) state_d = wfem_pkg::ST_DIV;
      wfem_pkg::ST_DIV:  if (bit_q == 3'd7) state_d = wfem_pkg::ST_FIX;
      wfem_pkg::ST_FIX:  state_d = wfem_pkg::ST_RUN;
      wfem_pkg::ST_RUN:  if (issue && last_issue) state_d = wfem_pkg::ST_IDLE;
      default:           state_d = wfem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    div_en      = 1'b0;
    fix_en      = 1'b0;
    issue       = 1'b0;
    case (state_q)
      wfem_pkg::ST_IDLE: req_i.ready = 1'b1;
      wfem_pkg::ST_DIV:  div_en = 1'b1;
      wfem_pkg::ST_FIX:  fix_en = 1'b1;
      wfem_pkg::ST_RUN:  issue = credit_ok;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wfem_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // coordinate walk
  logic signed [RW-1:0] rx_q, ry_q, ry0_q, rx_start, ry_start;
  logic [CW-1:0]        divx_q, divy_q;
  logic                 negx_q, negy_q;
  logic [SW-1:0]        remx_q, remy_q, remx_d, remy_d;
  logic [SW:0]          tx, ty;
  logic [SW-1:0]        wx_q, wy_q, wy0_q, wx_fix, wy_fix, wx_inc, wy_inc;

  assign rx_start = RW'(req_i.coord_x) - RW'(half);
  assign ry_start = RW'(req_i.coord_y) - RW'(half);

  assign tx     = {remx_q, divx_q[CW-1]};
  assign ty     = {remy_q, divy_q[CW-1]};
  assign remx_d = (tx >= {1'b0, eff_w}) ? SW'(tx - {1'b0, eff_w}) : tx[SW-1:0];
  assign remy_d = (ty >= {1'b0, eff_h}) ? SW'(ty - {1'b0, eff_h}) : ty[SW-1:0];
  assign wx_fix = (negx_q && remx_q != '0) ? eff_w - remx_q : remx_q;
  assign wy_fix = (negy_q && remy_q != '0) ? eff_h - remy_q : remy_q;
  assign wx_inc = wx_q + SW'(1);
  assign wy_inc = wy_q + SW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      if (start) begin
        bit_q <= '0;
        col_q <= '0;
        row_q <= '0;
      end else if (div_en) begin
        bit_q <= bit_q + 3'd1;
      end else if (issue) begin
        if (row_q == last_idx) begin
          row_q <= '0;
          col_q <= col_q + OW'(1);
        end else begin
          row_q <= row_q + OW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      rx_q   <= rx_start;
      ry_q   <= ry_start;
      ry0_q  <= ry_start;
      negx_q <= rx_start[RW-1];
      negy_q <= ry_start[RW-1];
      divx_q <= rx_start[RW-1] ? CW'(-rx_start) : CW'(rx_start);
      divy_q <= ry_start[RW-1] ? CW'(-ry_start) : CW'(ry_start);
      remx_q <= '0;
      remy_q <= '0;
    end else if (div_en) begin
      remx_q <= remx_d;
      remy_q <= remy_d;
      divx_q <= {divx_q[CW-2:0], 1'b0};
      divy_q <= {divy_q[CW-2:0], 1'b0};
    end else if (fix_en) begin
      wx_q  <= wx_fix;
      wy_q  <= wy_fix;
      wy0_q <= wy_fix;
    end else if (issue) begin
      if (row_q == last_idx) begin
        ry_q <= ry0_q;
        wy_q <= wy0_q;
        rx_q <= rx_q + RW'(1);
        wx_q <= (wx_inc == eff_w) ? '0 : wx_inc;
      end else begin
        ry_q <= ry_q + RW'(1);
        wy_q <= (wy_inc == eff_h) ? '0 : wy_inc;
      end
    end
  end

  // pixel memory
  wfem_pkg::resolved_t res_x, res_y;
  logic [15:0]             ax, ay, wax, way;
  logic [AW-1:0]           raddr, waddr;
  logic                    mem_we;
  logic [wfem_pkg::RGB_W-1:0] mem_q [DEPTH];
  logic [wfem_pkg::RGB_W-1:0] rdata_q;

  assign res_x = wfem_pkg::resolve(rx_q, wx_q, eff_w, mode_q);
  assign res_y = wfem_pkg::resolve(ry_q, wy_q, eff_h, mode_q);
  assign ax    = 16'(res_x.coord);
  assign ay    = 16'(res_y.coord);
  assign raddr = {ay[YW-1:0], ax[XW-1:0]};
  assign wax   = 16'(req_i.coord_x);
  assign way   = 16'(req_i.coord_y);
  assign waddr = {way[YW-1:0], wax[XW-1:0]};
  assign mem_we = req_fire && (req_i.cmd == wfem_pkg::CMD_WRITE) &&
                  (32'(req_i.coord_x) < MAX_WIDTH) && (32'(req_i.coord_y) < MAX_HEIGHT);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= req_i.pixel_rgb;
    end
    if (issue) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // read stage
  logic           p1_valid_q;
  wfem_pkg::tag_t p1_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p1_tag_q.black <= !(res_x.ok && res_y.ok);
      p1_tag_q.col   <= col_q;
      p1_tag_q.row   <= row_q;
      p1_tag_q.last  <= last_issue;
    end
  end

  // output queue, two entries
  wfem_pkg::sample_t push_item;
  wfem_pkg::sample_t fifo_q [2];
  logic              wr_ptr_q, rd_ptr_q, pop;
  logic [1:0]        cnt_q;

  assign push_item.sample_value   = wfem_pkg::channel_of(
                                      p1_tag_q.black ? '0 : rdata_q, chan_q);
  assign push_item.offset_col     = p1_tag_q.col;
  assign push_item.offset_row     = p1_tag_q.row;
  assign push_item.last_of_window = p1_tag_q.last;

  assign smp_o.valid          = (cnt_q != 2'd0);
  assign pop                  = smp_o.valid & smp_o.ready;
  assign smp_o.sample_value   = fifo_q[rd_ptr_q].sample_value;
  assign smp_o.offset_col     = fifo_q[rd_ptr_q].offset_col;
  assign smp_o.offset_row     = fifo_q[rd_ptr_q].offset_row;
  assign smp_o.last_of_window = fifo_q[rd_ptr_q].last_of_window;
  assign credit_ok = ({1'b0, cnt_q} + {2'b0, p1_valid_q}) < (3'd2 + {2'b0, pop});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (p1_valid_q) wr_ptr_q <= ~wr_ptr_q;
      if (pop)        rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, p1_valid_q} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_valid_q) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wfem_checker.sv
`default_nettype none

module wfem_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          smp_valid_i,
  input logic                          smp_ready_i,
  input logic [wfem_pkg::SAMPLE_W-1:0] sample_value_i,
  input logic [wfem_pkg::OFS_W-1:0]    offset_col_i,
  input logic [wfem_pkg::OFS_W-1:0]    offset_row_i,
  input logic                          last_of_window_i
);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i && !smp_ready_i |=> smp_valid_i && $stable(sample_value_i) &&
    $stable(offset_col_i) && $stable(offset_row_i) && $stable(last_of_window_i))
    else $error("stalled item changed");

  a_last_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i && last_of_window_i |-> offset_col_i == offset_row_i &&
    offset_col_i[0] == 1'b0)
    else $error("last item not at far corner of window");

  a_first_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i && smp_ready_i && last_of_window_i |=>
    !smp_valid_i || (offset_col_i == '0 && offset_row_i == '0))
    else $error("window does not start at origin");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !smp_valid_i)
    else $error("item shown during reset");

endmodule

bind window_fetch_with_edge_modes_core wfem_checker u_wfem_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .smp_valid_i     (smp_o.valid),
  .smp_ready_i     (smp_o.ready),
  .sample_value_i  (smp_o.sample_value),
  .offset_col_i    (smp_o.offset_col),
  .offset_row_i    (smp_o.offset_row),
  .last_of_window_i(smp_o.last_of_window)
);

`default_nettype wire

FILE: sim/tb_window_fetch_with_edge_modes_core.sv
`timescale 1ns / 1ps

module tb_window_fetch_with_edge_modes_core;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 24;
  localparam int ITEM_TARGET = 170;
  localparam logic [wfem_pkg::MODE_W-1:0] EDGE_UNUSED = 2'd3;

  typedef struct packed {
    logic                         cmd;
    logic [wfem_pkg::COORD_W-1:0] x;
    logic [wfem_pkg::COORD_W-1:0] y;
    logic [wfem_pkg::RGB_W-1:0]   rgb;
  } pixel_op_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [wfem_pkg::APB_AW-1:0] paddr;
  logic [wfem_pkg::APB_DW-1:0] pwdata;
  logic [wfem_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  wfem_req_if req_bus();
  wfem_smp_if smp_bus();

  window_fetch_with_edge_modes_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_bus),
    .smp_o   (smp_bus)
  );

  // shadow of the configuration registers
  logic [wfem_pkg::SIZE_W-1:0] img_w;
  logic [wfem_pkg::SIZE_W-1:0] img_h;
  logic [wfem_pkg::SIDE_W-1:0] win_side;
  logic [wfem_pkg::MODE_W-1:0] edge_sel;
  logic [1:0]                  chan_sel;

  logic [wfem_pkg::RGB_W-1:0] image_mem [0:65535];
  bit                         written_map [0:65535];

  pixel_op_t          pending_q[$];
  wfem_pkg::sample_t  expect_q[$];

  int  err_cnt;
  int  cycle_cnt;
  int  sent_cnt;
  int  send_gap;
  int  send_calm;
  int  recv_stall;
  int  recv_calm;
  bit  hold_send;
  logic req_taken;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(99) < 3) begin
      calm = $urandom_range(150, 40);
      return 0;
    end
    if ($urandom_range(99) < 55) return 0;
    if ($urandom_range(99) < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic int eff_dim(input logic [wfem_pkg::SIZE_W-1:0] v,
                                 input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int win_half();
    int hf;
    hf = int'(win_side) / 2;
    if (hf > (wfem_pkg::MAX_WINDOW_DEF - 1) / 2) hf = (wfem_pkg::MAX_WINDOW_DEF - 1) / 2;
    return hf;
  endfunction

  // map one coordinate into the image; 0 means black
  function automatic bit fold_coord(input int c, input int n, output int res);
    res = 0;
    if (c >= 0 && c < n) begin
      res = c;
      return 1'b1;
    end
    case (edge_sel)
      wfem_pkg::EDGE_WRAP: begin
        res = c % n;
        if (res < 0) res += n;
        return 1'b1;
      end
      wfem_pkg::EDGE_CLAMP: begin
        res = (c < 0) ? 0 : n - 1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [wfem_pkg::SAMPLE_W-1:0] pick_channel(
      input logic [wfem_pkg::RGB_W-1:0] px);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    r = px[23:16];
    g = px[15:8];
    b = px[7:0];
    case (chan_sel)
      wfem_pkg::CH_RED:   return r[7:0];
      wfem_pkg::CH_GREEN: return g[7:0];
      wfem_pkg::CH_BLUE:  return b[7:0];
      default:            return wfem_pkg::SAMPLE_W'((r * 11 + g * 16 + b * 5) / 32);
    endcase
  endfunction

  function automatic void predict_window(input int cx, input int cy);
    int w;
    int h;
    int half;
    int n;
    int px;
    int py;
    logic [wfem_pkg::RGB_W-1:0] pix;
    wfem_pkg::sample_t s;
    w = eff_dim(img_w, wfem_pkg::MAX_WIDTH_DEF);
    h = eff_dim(img_h, wfem_pkg::MAX_HEIGHT_DEF);
    half = win_half();
    n = 2 * half + 1;
    for (int a = 0; a < n; a++) begin
      for (int b = 0; b < n; b++) begin
        pix = '0;
        if (fold_coord(cx - half + a, w, px) && fold_coord(cy - half + b, h, py))
          pix = image_mem[py * wfem_pkg::MAX_WIDTH_DEF + px];
        s.sample_value   = pick_channel(pix);
        s.offset_col     = wfem_pkg::OFS_W'(a);
        s.offset_row     = wfem_pkg::OFS_W'(b);
        s.last_of_window = (a == n - 1) && (b == n - 1);
        expect_q.push_back(s);
      end
    end
  endfunction

  function automatic void queue_write(input logic [wfem_pkg::COORD_W-1:0] x,
                                      input logic [wfem_pkg::COORD_W-1:0] y,
                                      input logic [wfem_pkg::RGB_W-1:0] rgb);
    pending_q.push_back('{cmd: wfem_pkg::CMD_WRITE, x: x, y: y, rgb: rgb});
    written_map[{y, x}] = 1'b1;
    sent_cnt++;
  endfunction

  // fill every pixel the window touches that was never written, then request it
  function automatic void load_window(input int cx, input int cy);
    int w;
    int h;
    int half;
    int n;
    int px;
    int py;
    w = eff_dim(img_w, wfem_pkg::MAX_WIDTH_DEF);
    h = eff_dim(img_h, wfem_pkg::MAX_HEIGHT_DEF);
    half = win_half();
    n = 2 * half + 1;
    for (int a = 0; a < n; a++) begin
      for (int b = 0; b < n; b++) begin
        if (fold_coord(cx - half + a, w, px) && fold_coord(cy - half + b, h, py) &&
            !written_map[py * wfem_pkg::MAX_WIDTH_DEF + px])
          queue_write(wfem_pkg::COORD_W'(px), wfem_pkg::COORD_W'(py),
                      wfem_pkg::RGB_W'($urandom));
      end
    end
    pending_q.push_back('{cmd: wfem_pkg::CMD_WINDOW, x: wfem_pkg::COORD_W'(cx),
                          y: wfem_pkg::COORD_W'(cy), rgb: wfem_pkg::RGB_W'($urandom)});
    sent_cnt++;
  endfunction

  function automatic logic [wfem_pkg::SIZE_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return '0;
      1:       return wfem_pkg::SIZE_W'(256);
      2:       return wfem_pkg::SIZE_W'($urandom_range(511, 257));
      3, 4, 5: return wfem_pkg::SIZE_W'($urandom_range(8, 1));
      default: return wfem_pkg::SIZE_W'($urandom_range(256, 1));
    endcase
  endfunction

  function automatic logic [wfem_pkg::COORD_W-1:0] pick_centre(input int n);
    int r;
    r = $urandom_range(99);
    if (r < 45) return wfem_pkg::COORD_W'($urandom_range(n - 1));
    if (r < 75) return wfem_pkg::COORD_W'($urandom_range(15));
    return wfem_pkg::COORD_W'($urandom);
  endfunction

  function automatic logic [wfem_pkg::APB_DW-1:0] reg_shadow(input logic [2:0] idx);
    case (idx)
      wfem_pkg::REG_IMAGE_WIDTH:    return wfem_pkg::APB_DW'(img_w);
      wfem_pkg::REG_IMAGE_HEIGHT:   return wfem_pkg::APB_DW'(img_h);
      wfem_pkg::REG_WINDOW_SIDE:    return wfem_pkg::APB_DW'(win_side);
      wfem_pkg::REG_EDGE_MODE:      return wfem_pkg::APB_DW'(edge_sel);
      wfem_pkg::REG_CHANNEL_SELECT: return wfem_pkg::APB_DW'(chan_sel);
      default:                      return '0;
    endcase
  endfunction

  task automatic apb_cycle(input logic [2:0] idx, input logic wr,
                           input logic [wfem_pkg::APB_DW-1:0] wdata,
                           output logic [wfem_pkg::APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= wfem_pkg::APB_AW'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic verify_reg(input logic [2:0] idx);
    logic [wfem_pkg::APB_DW-1:0] rdata;
    apb_cycle(idx, 1'b0, '0, rdata);
    if (rdata !== reg_shadow(idx))
      flag_error($sformatf("register %0d reads %0h, want %0h", idx, rdata, reg_shadow(idx)));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [wfem_pkg::APB_DW-1:0] val);
    logic [wfem_pkg::APB_DW-1:0] rdata;
    apb_cycle(idx, 1'b1, val, rdata);
    case (idx)
      wfem_pkg::REG_IMAGE_WIDTH:    img_w = val[wfem_pkg::SIZE_W-1:0];
      wfem_pkg::REG_IMAGE_HEIGHT:   img_h = val[wfem_pkg::SIZE_W-1:0];
      wfem_pkg::REG_WINDOW_SIDE:    win_side = val[wfem_pkg::SIDE_W-1:0];
      wfem_pkg::REG_EDGE_MODE:      edge_sel = val[wfem_pkg::MODE_W-1:0];
      wfem_pkg::REG_CHANNEL_SELECT: chan_sel = val[1:0];
      default: ;
    endcase
    verify_reg(idx);
  endtask

  task automatic wait_idle(input int settle);
    while (pending_q.size() != 0 || req_bus.valid || expect_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [wfem_pkg::SIZE_W-1:0] w,
                              input logic [wfem_pkg::SIZE_W-1:0] h,
                              input logic [wfem_pkg::SIDE_W-1:0] side,
                              input logic [wfem_pkg::MODE_W-1:0] mode,
                              input logic [1:0] chan);
    wait_idle(SETTLE);
    write_reg(wfem_pkg::REG_IMAGE_WIDTH, wfem_pkg::APB_DW'(w));
    write_reg(wfem_pkg::REG_IMAGE_HEIGHT, wfem_pkg::APB_DW'(h));
    write_reg(wfem_pkg::REG_WINDOW_SIDE, wfem_pkg::APB_DW'(side));
    write_reg(wfem_pkg::REG_EDGE_MODE, wfem_pkg::APB_DW'(mode));
    write_reg(wfem_pkg::REG_CHANNEL_SELECT, wfem_pkg::APB_DW'(chan));
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // track accepted items: store writes, predict windows
  always @(posedge clk_i) begin
    req_taken <= rst_ni && req_bus.valid && req_bus.ready;
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      if (req_bus.cmd == wfem_pkg::CMD_WRITE) begin
        image_mem[{req_bus.coord_y, req_bus.coord_x}] = req_bus.pixel_rgb;
      end else begin
        predict_window(req_bus.coord_x, req_bus.coord_y);
      end
    end
  end

  always @(negedge clk_i) begin
    pixel_op_t op;
    if (rst_ni && (!req_bus.valid || req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        req_bus.valid <= 1'b0;
      end else if (!hold_send && pending_q.size() != 0) begin
        op = pending_q.pop_front();
        req_bus.valid     <= 1'b1;
        req_bus.cmd       <= op.cmd;
        req_bus.coord_x   <= op.x;
        req_bus.coord_y   <= op.y;
        req_bus.pixel_rgb <= op.rgb;
        send_gap = draw_gap(send_calm);
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (recv_stall > 0) begin
      recv_stall--;
      smp_bus.ready <= 1'b0;
    end else begin
      smp_bus.ready <= 1'b1;
      if ($urandom_range(99) < 20) recv_stall = draw_gap(recv_calm);
    end
  end

  always @(posedge clk_i) begin
    wfem_pkg::sample_t want;
    if (rst_ni && smp_bus.valid && smp_bus.ready) begin
      if (expect_q.size() == 0) begin
        flag_error($sformatf("sample %0h col %0d row %0d with no window pending",
                             smp_bus.sample_value, smp_bus.offset_col, smp_bus.offset_row));
      end else begin
        want = expect_q.pop_front();
        check_field("sample_value", smp_bus.sample_value, want.sample_value);
        check_field("offset_col", 8'(smp_bus.offset_col), 8'(want.offset_col));
        check_field("offset_row", 8'(smp_bus.offset_row), 8'(want.offset_row));
        check_field("last_of_window", 8'(smp_bus.last_of_window), 8'(want.last_of_window));
      end
    end
  end

  initial begin
    int w;
    int h;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_bus.valid     = 1'b0;
    req_bus.cmd       = wfem_pkg::CMD_WRITE;
    req_bus.coord_x   = '0;
    req_bus.coord_y   = '0;
    req_bus.pixel_rgb = '0;
    smp_bus.ready     = 1'b0;
    req_taken         = 1'b0;
    hold_send         = 1'b0;
    img_w             = wfem_pkg::SIZE_W'(256);
    img_h             = wfem_pkg::SIZE_W'(256);
    win_side          = wfem_pkg::SIDE_W'(3);
    edge_sel          = wfem_pkg::EDGE_BLACK;
    chan_sel          = wfem_pkg::CH_GRAY;
    rst_ni            = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i <= wfem_pkg::REG_CHANNEL_SELECT; i++) verify_reg(3'(i));

    // reset settings: corners with black outside, full-scale pixels
    queue_write(8'd1, 8'd1, 24'h000000);
    load_window(0, 0);
    queue_write(8'd254, 8'd254, 24'hFFFFFF);
    load_window(255, 255);
    load_window(128, 7);

    // hold the sender until every window accepted so far has drained
    while (expect_q.size() == 0) @(posedge clk_i);
    hold_send = 1'b1;
    while (expect_q.size() != 0) @(posedge clk_i);
    hold_send = 1'b0;

    apply_config(wfem_pkg::SIZE_W'(2), wfem_pkg::SIZE_W'(2), wfem_pkg::SIDE_W'(7),
                 wfem_pkg::EDGE_WRAP, wfem_pkg::CH_RED);
    load_window(0, 0);
    load_window(1, 1);
    load_window(200, 9);

    apply_config('0, wfem_pkg::SIZE_W'(300), wfem_pkg::SIDE_W'(6),
                 wfem_pkg::EDGE_CLAMP, wfem_pkg::CH_GREEN);
    load_window(0, 255);
    load_window(40, 0);

    apply_config(wfem_pkg::SIZE_W'(256), wfem_pkg::SIZE_W'(1), '0, EDGE_UNUSED,
                 wfem_pkg::CH_BLUE);
    load_window(3, 0);
    load_window(3, 200);

    apply_config(wfem_pkg::SIZE_W'(511), wfem_pkg::SIZE_W'(5), wfem_pkg::SIDE_W'(1),
                 wfem_pkg::EDGE_BLACK, wfem_pkg::CH_GRAY);
    load_window(255, 4);

    while (sent_cnt < ITEM_TARGET) begin
      apply_config(pick_dim(), pick_dim(), wfem_pkg::SIDE_W'($urandom_range(7)),
                   wfem_pkg::MODE_W'($urandom_range(3)), 2'($urandom_range(3)));
      w = eff_dim(img_w, wfem_pkg::MAX_WIDTH_DEF);
      h = eff_dim(img_h, wfem_pkg::MAX_HEIGHT_DEF);
      repeat ($urandom_range(12, 4)) begin
        if (sent_cnt < ITEM_TARGET) begin
          if ($urandom_range(99) < 20) begin
            queue_write(wfem_pkg::COORD_W'($urandom), wfem_pkg::COORD_W'($urandom),
                        wfem_pkg::RGB_W'($urandom));
          end else begin
            load_window(pick_centre(w), pick_centre(h));
          end
        end
      end
    end

    wait_idle(3 * SETTLE);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/wfem_pkg.sv
hw/rtl/wfem_if.sv
hw/rtl/window_fetch_with_edge_modes_core.sv
hw/rtl/wfem_checker.sv
sim/tb_window_fetch_with_edge_modes_core.sv
